// ----- src/iomd_pkg.sv -----
`default_nettype none
package iomd_pkg;

   localparam int TQ_DEPTH_DEF = 2;
   localparam int RQ_DEPTH_DEF = 2;

   localparam logic [7:0] TYPE_ADD      = 8'h41;
   localparam logic [7:0] TYPE_ADD_ATTR = 8'h46;
   localparam logic [7:0] TYPE_EXEC     = 8'h45;
   localparam logic [7:0] TYPE_CANCEL   = 8'h58;
   localparam logic [7:0] TYPE_DELETE   = 8'h44;
   localparam logic [7:0] TYPE_REPLACE  = 8'h55;
   localparam logic [7:0] SIDE_BUY      = 8'h42;

   typedef enum logic [2:0] {
      CMD_ADD       = 3'd0,
      CMD_EXECUTED  = 3'd1,
      CMD_CANCEL    = 3'd2,
      CMD_DELETE    = 3'd3,
      CMD_REPLACE   = 3'd4,
      CMD_MALFORMED = 3'd5,
      CMD_SKIPPED   = 3'd6
   } cmd_type;

   // one body byte with its framing position
   typedef struct packed {
      logic [7:0]  data;
      logic [15:0] pos;
      logic [15:0] len;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] order_ref;
      logic [63:0] new_ref;
      logic        side_sell;
      logic [31:0] share_count;
      logic [31:0] limit_price;
      logic [31:0] processed_count;
      logic [31:0] malformed_count;
      logic [31:0] skipped_count;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/iomd_fifo.sv -----
`default_nettype none
module iomd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ----- src/iomd_front.sv -----
`default_nettype none
module iomd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   output logic              in_full,
   input  logic              in_kind,
   input  logic [7:0]        in_byte,
   output logic              tok_push,
   output iomd_pkg::tok_type tok_data,
   input  logic              tok_full
);
   import iomd_pkg::*;

   typedef enum logic [1:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY,
      PH_HALT
   } phase_type;

   phase_type   phase_ff;
   logic [15:0] len_ff;
   logic [15:0] pos_ff;
   logic        accept;
   logic        last;
   logic [15:0] len_lo;

   assign in_full  = tok_full;
   assign accept   = in_push && !tok_full;
   assign last     = ({1'b0, pos_ff} + 17'd1) >= {1'b0, len_ff};
   assign len_lo   = {len_ff[15:8], in_byte};
   assign tok_push = accept && !in_kind && (phase_ff == PH_BODY);

   always_comb begin
      tok_data.data = in_byte;
      tok_data.pos  = pos_ff;
      tok_data.len  = len_ff;
      tok_data.last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN_HI;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else if (accept) begin
         if (in_kind) begin
            // end of stream: drop partial message and restart framing
            phase_ff <= PH_LEN_HI;
            len_ff   <= '0;
            pos_ff   <= '0;
         end else begin
            unique case (phase_ff)
               PH_LEN_HI: begin
                  len_ff   <= {in_byte, 8'h00};
                  phase_ff <= PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len_ff   <= len_lo;
                  pos_ff   <= '0;
                  phase_ff <= (len_lo == '0) ? PH_HALT : PH_BODY;
               end
               PH_BODY: begin
                  if (last) begin
                     pos_ff   <= '0;
                     phase_ff <= PH_LEN_HI;
                  end else begin
                     pos_ff <= pos_ff + 16'd1;
                  end
               end
               PH_HALT: begin
                  phase_ff <= PH_HALT;
               end
               default: begin
                  phase_ff <= PH_LEN_HI;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/iomd_back.sv -----
`default_nettype none
module iomd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_empty,
   input  iomd_pkg::tok_type tok_data,
   output logic              tok_pop,
   output logic              rsp_push,
   output iomd_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);
   import iomd_pkg::*;

   localparam logic [15:0] REF_LO      = 16'd11;
   localparam logic [15:0] SIDE_POS    = 16'd19;
   localparam logic [15:0] ADD_SH_LO   = 16'd20;
   localparam logic [15:0] ADD_PR_LO   = 16'd32;
   localparam logic [15:0] EX_SH_LO    = 16'd19;
   localparam logic [15:0] RP_NREF_LO  = 16'd19;
   localparam logic [15:0] RP_SH_LO    = 16'd27;
   localparam logic [15:0] RP_PR_LO    = 16'd31;
   localparam logic [15:0] NEED_ADD    = 16'd36;
   localparam logic [15:0] NEED_EXEC   = 16'd31;
   localparam logic [15:0] NEED_CANCEL = 16'd23;
   localparam logic [15:0] NEED_DELETE = 16'd19;
   localparam logic [15:0] NEED_REPL   = 16'd35;

   logic [7:0]  type_ff, type_in;
   logic [63:0] ref_ff, ref_in;
   logic [63:0] nref_ff, nref_in;
   logic        side_ff, side_in;
   logic [31:0] shares_ff, shares_in;
   logic [31:0] price_ff, price_in;
   logic [31:0] proc_ff, proc_in;
   logic [31:0] malf_ff, malf_in;
   logic [31:0] skip_ff, skip_in;
   logic        take;
   logic        finish;
   logic [15:0] need;
   cmd_type     kind_cmd;
   logic [7:0]  b;
   logic [15:0] p;

   function automatic logic in_span(input logic [15:0] pos, input logic [15:0] lo,
                                    input logic [15:0] n);
      in_span = (pos >= lo) && ({1'b0, pos} < ({1'b0, lo} + {1'b0, n}));
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == '1) ? v : v + 32'd1;
   endfunction

   assign take     = !tok_empty && !rsp_full;
   assign tok_pop  = take;
   assign finish   = take && tok_data.last;
   assign rsp_push = finish;
   assign b        = tok_data.data;
   assign p        = tok_data.pos;

   // field capture
   always_comb begin
      type_in   = type_ff;
      ref_in    = ref_ff;
      nref_in   = nref_ff;
      side_in   = side_ff;
      shares_in = shares_ff;
      price_in  = price_ff;
      if (take) begin
         if (p == '0) begin
            type_in   = b;
            ref_in    = '0;
            nref_in   = '0;
            side_in   = 1'b0;
            shares_in = '0;
            price_in  = '0;
         end else begin
            if (in_span(p, REF_LO, 16'd8)) begin
               ref_in = {ref_ff[55:0], b};
            end
            case (type_ff) inside
               TYPE_ADD, TYPE_ADD_ATTR: begin
                  if (p == SIDE_POS) begin
                     side_in = (b != SIDE_BUY);
                  end
                  if (in_span(p, ADD_SH_LO, 16'd4)) begin
                     shares_in = {shares_ff[23:0], b};
                  end
                  if (in_span(p, ADD_PR_LO, 16'd4)) begin
                     price_in = {price_ff[23:0], b};
                  end
               end
               TYPE_EXEC, TYPE_CANCEL: begin
                  if (in_span(p, EX_SH_LO, 16'd4)) begin
                     shares_in = {shares_ff[23:0], b};
                  end
               end
               TYPE_REPLACE: begin
                  if (in_span(p, RP_NREF_LO, 16'd8)) begin
                     nref_in = {nref_ff[55:0], b};
                  end
                  if (in_span(p, RP_SH_LO, 16'd4)) begin
                     shares_in = {shares_ff[23:0], b};
                  end
                  if (in_span(p, RP_PR_LO, 16'd4)) begin
                     price_in = {price_ff[23:0], b};
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // message type decode
   always_comb begin
      unique case (type_in) inside
         TYPE_ADD, TYPE_ADD_ATTR: begin
            need     = NEED_ADD;
            kind_cmd = CMD_ADD;
         end
         TYPE_EXEC: begin
            need     = NEED_EXEC;
            kind_cmd = CMD_EXECUTED;
         end
         TYPE_CANCEL: begin
            need     = NEED_CANCEL;
            kind_cmd = CMD_CANCEL;
         end
         TYPE_DELETE: begin
            need     = NEED_DELETE;
            kind_cmd = CMD_DELETE;
         end
         TYPE_REPLACE: begin
            need     = NEED_REPL;
            kind_cmd = CMD_REPLACE;
         end
         default: begin
            need     = '0;
            kind_cmd = CMD_SKIPPED;
         end
      endcase
   end

   // result build and counters
   always_comb begin
      proc_in = proc_ff;
      malf_in = malf_ff;
      skip_in = skip_ff;
      rsp_data             = '0;
      rsp_data.cmd         = kind_cmd;
      if (finish) begin
         proc_in = sat_inc(proc_ff);
      end
      if (kind_cmd == CMD_SKIPPED) begin
         if (finish) begin
            skip_in = sat_inc(skip_ff);
         end
      end else if (tok_data.len < need) begin
         rsp_data.cmd = CMD_MALFORMED;
         if (finish) begin
            malf_in = sat_inc(malf_ff);
         end
      end else begin
         rsp_data.order_ref = ref_in;
         unique case (kind_cmd)
            CMD_ADD: begin
               rsp_data.side_sell   = side_in;
               rsp_data.share_count = shares_in;
               rsp_data.limit_price = price_in;
            end
            CMD_EXECUTED, CMD_CANCEL: begin
               rsp_data.share_count = shares_in;
            end
            CMD_REPLACE: begin
               rsp_data.new_ref     = nref_in;
               rsp_data.share_count = shares_in;
               rsp_data.limit_price = price_in;
            end
            default: begin
            end
         endcase
      end
      rsp_data.processed_count = proc_in;
      rsp_data.malformed_count = malf_in;
      rsp_data.skipped_count   = skip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= '0;
         ref_ff    <= '0;
         nref_ff   <= '0;
         side_ff   <= 1'b0;
         shares_ff <= '0;
         price_ff  <= '0;
         proc_ff   <= '0;
         malf_ff   <= '0;
         skip_ff   <= '0;
      end else begin
         type_ff   <= type_in;
         ref_ff    <= ref_in;
         nref_ff   <= nref_in;
         side_ff   <= side_in;
         shares_ff <= shares_in;
         price_ff  <= price_in;
         proc_ff   <= proc_in;
         malf_ff   <= malf_in;
         skip_ff   <= skip_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/itch_order_message_decoder_core.sv -----
// itch order message decoder
// input queue side: one word per push, req_kind 0 carries a stream byte in
// req_in_byte, req_kind 1 marks end of stream. a word is taken on a rising
// edge with req_push high and req_full low.
// the stream is 2-byte big-endian length words followed by a body; add,
// executed, cancel, delete and replace bodies are decoded, and one result word
// comes out on the last body byte of each message with three saturating
// counters. length bytes, halted bytes and end of stream give no result.
// result queue side: the oldest result is on the rsp_ ports while rsp_empty is
// low and is taken on a rising edge with rsp_pop high.
// throughput is one byte per cycle while no queue is full: the framer takes
// a byte each cycle into a TQ_DEPTH token queue, and the field capture unit
// drains one token a cycle. the last byte is registered in the token queue,
// then its result in the RQ_DEPTH result queue; when the consumer stalls,
// results collect there, capture stops, tokens back up, and req_full rises.
// reset (synchronous) empties both queues, restarts framing at the length
// high byte and clears all counters.
`default_nettype none
module itch_order_message_decoder_core #(
   parameter int TQ_DEPTH = iomd_pkg::TQ_DEPTH_DEF,
   parameter int RQ_DEPTH = iomd_pkg::RQ_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_cmd,
   output logic [63:0] rsp_order_ref,
   output logic [63:0] rsp_new_ref,
   output logic        rsp_side_sell,
   output logic [31:0] rsp_share_count,
   output logic [31:0] rsp_limit_price,
   output logic [31:0] rsp_processed_count,
   output logic [31:0] rsp_malformed_count,
   output logic [31:0] rsp_skipped_count
);
   import iomd_pkg::*;

   localparam int TOK_W = $bits(tok_type);
   localparam int RSP_W = $bits(rsp_type);

   logic             tq_push, tq_full, tq_pop, tq_empty;
   tok_type          tq_wdata, tq_rdata;
   logic [TOK_W-1:0] tq_rvec;
   logic             rq_push, rq_full;
   rsp_type          rq_wdata, rq_rdata;
   logic [RSP_W-1:0] rq_rvec;

   iomd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (req_push),
      .in_full  (req_full),
      .in_kind  (req_kind),
      .in_byte  (req_in_byte),
      .tok_push (tq_push),
      .tok_data (tq_wdata),
      .tok_full (tq_full)
   );

   iomd_fifo #(
      .WIDTH (TOK_W),
      .DEPTH (TQ_DEPTH)
   ) u_tok_queue (
      .clock (clock),
      .reset (reset),
      .push  (tq_push),
      .wdata (tq_wdata),
      .full  (tq_full),
      .pop   (tq_pop),
      .rdata (tq_rvec),
      .empty (tq_empty)
   );

   assign tq_rdata = tok_type'(tq_rvec);

   iomd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (tq_empty),
      .tok_data  (tq_rdata),
      .tok_pop   (tq_pop),
      .rsp_push  (rq_push),
      .rsp_data  (rq_wdata),
      .rsp_full  (rq_full)
   );

   iomd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RQ_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata (rq_wdata),
      .full  (rq_full),
      .pop   (rsp_pop),
      .rdata (rq_rvec),
      .empty (rsp_empty)
   );

   assign rq_rdata            = rsp_type'(rq_rvec);
   assign rsp_cmd             = rq_rdata.cmd;
   assign rsp_order_ref       = rq_rdata.order_ref;
   assign rsp_new_ref         = rq_rdata.new_ref;
   assign rsp_side_sell       = rq_rdata.side_sell;
   assign rsp_share_count     = rq_rdata.share_count;
   assign rsp_limit_price     = rq_rdata.limit_price;
   assign rsp_processed_count = rq_rdata.processed_count;
   assign rsp_malformed_count = rq_rdata.malformed_count;
   assign rsp_skipped_count   = rq_rdata.skipped_count;

endmodule
`default_nettype wire

// ----- tb/tb_itch_order_message_decoder_core.sv -----
`timescale 1ns / 100ps
module tb_itch_order_message_decoder_core;
   import iomd_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_WORDS = 350;
   localparam int LONG_HOLD = 400;

   typedef enum logic [1:0] {
      WAIT_LEN_HI,
      WAIT_LEN_LO,
      IN_BODY,
      HALTED
   } frame_state_type;

   typedef struct packed {
      logic [7:0]  mtype;
      logic [63:0] oref;
      logic [63:0] nref;
      logic [7:0]  side;
      logic [31:0] shares;
      logic [31:0] price;
   } order_msg_type;

   typedef struct packed {
      order_msg_type m;
      logic [1:0]    len_bytes;
      logic [15:0]   len_field;
      logic [15:0]   body_sent;
      logic          eos_after;
      logic          typed;
      rsp_type       want;
   } probe_row_type;

   localparam rsp_type NO_RSP = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_cmd;
   logic [63:0] rsp_order_ref;
   logic [63:0] rsp_new_ref;
   logic        rsp_side_sell;
   logic [31:0] rsp_share_count;
   logic [31:0] rsp_limit_price;
   logic [31:0] rsp_processed_count;
   logic [31:0] rsp_malformed_count;
   logic [31:0] rsp_skipped_count;

   // expected decoder state
   frame_state_type frame_st = WAIT_LEN_HI;
   logic [15:0] body_len = '0;
   logic [15:0] body_at = '0;
   logic [7:0]  msg_kind = '0;
   logic [63:0] ref_bits = '0;
   logic [63:0] new_ref_bits = '0;
   logic        sell_bit = 1'b0;
   logic [31:0] share_bits = '0;
   logic [31:0] price_bits = '0;
   logic [31:0] n_processed = '0;
   logic [31:0] n_malformed = '0;
   logic [31:0] n_skipped = '0;

   rsp_type     cmds_due[$];
   logic        typed_ok = 1'b0;
   rsp_type     typed_word = '0;
   int          n_errors = 0;
   int          words_sent = 0;
   int          send_idle = 0;
   int          pop_stall = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          send_pcts[4] = '{0, 75, 0, 9};
   int          stall_pcts[4] = '{0, 0, 75, 9};
   probe_row_type probe_rows[23];

   itch_order_message_decoder_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_in_byte(req_in_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_cmd(rsp_cmd),
      .rsp_order_ref(rsp_order_ref),
      .rsp_new_ref(rsp_new_ref),
      .rsp_side_sell(rsp_side_sell),
      .rsp_share_count(rsp_share_count),
      .rsp_limit_price(rsp_limit_price),
      .rsp_processed_count(rsp_processed_count),
      .rsp_malformed_count(rsp_malformed_count),
      .rsp_skipped_count(rsp_skipped_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] sat_bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic decode_word(input logic k, input logic [7:0] b, output logic made,
                              output rsp_type res);
      int need;
      made = 1'b0;
      res = '0;
      need = 0;
      if (k) begin
         frame_st = WAIT_LEN_HI;
         body_len = '0;
         body_at = '0;
      end else begin
         case (frame_st)
            WAIT_LEN_HI: begin
               body_len = {b, 8'h00};
               frame_st = WAIT_LEN_LO;
            end
            WAIT_LEN_LO: begin
               body_len[7:0] = b;
               body_at = '0;
               frame_st = (body_len == 16'd0) ? HALTED : IN_BODY;
            end
            IN_BODY: begin
               if (body_at == 16'd0) begin
                  msg_kind = b;
                  ref_bits = '0;
                  new_ref_bits = '0;
                  sell_bit = 1'b0;
                  share_bits = '0;
                  price_bits = '0;
               end else begin
                  if (body_at >= 11 && body_at < 19) ref_bits = {ref_bits[55:0], b};
                  case (msg_kind)
                     TYPE_ADD, TYPE_ADD_ATTR: begin
                        if (body_at == 19) sell_bit = (b != SIDE_BUY);
                        if (body_at >= 20 && body_at < 24) share_bits = {share_bits[23:0], b};
                        if (body_at >= 32 && body_at < 36) price_bits = {price_bits[23:0], b};
                     end
                     TYPE_EXEC, TYPE_CANCEL: begin
                        if (body_at >= 19 && body_at < 23) share_bits = {share_bits[23:0], b};
                     end
                     TYPE_REPLACE: begin
                        if (body_at >= 19 && body_at < 27)
                           new_ref_bits = {new_ref_bits[55:0], b};
                        if (body_at >= 27 && body_at < 31) share_bits = {share_bits[23:0], b};
                        if (body_at >= 31 && body_at < 35) price_bits = {price_bits[23:0], b};
                     end
                     default: ;
                  endcase
               end
               if (body_at + 1 >= body_len) begin
                  made = 1'b1;
                  body_at = '0;
                  frame_st = WAIT_LEN_HI;
                  res.cmd = CMD_SKIPPED;
                  case (msg_kind)
                     TYPE_ADD, TYPE_ADD_ATTR: begin
                        res.cmd = CMD_ADD;
                        need = 36;
                     end
                     TYPE_EXEC: begin
                        res.cmd = CMD_EXECUTED;
                        need = 31;
                     end
                     TYPE_CANCEL: begin
                        res.cmd = CMD_CANCEL;
                        need = 23;
                     end
                     TYPE_DELETE: begin
                        res.cmd = CMD_DELETE;
                        need = 19;
                     end
                     TYPE_REPLACE: begin
                        res.cmd = CMD_REPLACE;
                        need = 35;
                     end
                     default: ;
                  endcase
                  n_processed = sat_bump(n_processed);
                  if (res.cmd == CMD_SKIPPED) begin
                     n_skipped = sat_bump(n_skipped);
                  end else if (body_len < need) begin
                     res.cmd = CMD_MALFORMED;
                     n_malformed = sat_bump(n_malformed);
                  end else begin
                     res.order_ref = ref_bits;
                     case (res.cmd)
                        CMD_ADD: begin
                           res.side_sell = sell_bit;
                           res.share_count = share_bits;
                           res.limit_price = price_bits;
                        end
                        CMD_EXECUTED, CMD_CANCEL: begin
                           res.share_count = share_bits;
                        end
                        CMD_REPLACE: begin
                           res.new_ref = new_ref_bits;
                           res.share_count = share_bits;
                           res.limit_price = price_bits;
                        end
                        default: ;
                     endcase
                  end
                  res.processed_count = n_processed;
                  res.malformed_count = n_malformed;
                  res.skipped_count = n_skipped;
               end else begin
                  body_at = body_at + 16'd1;
               end
            end
            default: ;
         endcase
      end
   endtask

   function automatic logic [7:0] msg_byte(order_msg_type m, int p);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (p == 0) begin
         b = m.mtype;
      end else if (p >= 11 && p < 19) begin
         b = m.oref[8*(18-p) +: 8];
      end else begin
         case (m.mtype)
            TYPE_ADD, TYPE_ADD_ATTR: begin
               if (p == 19) b = m.side;
               else if (p >= 20 && p < 24) b = m.shares[8*(23-p) +: 8];
               else if (p >= 32 && p < 36) b = m.price[8*(35-p) +: 8];
            end
            TYPE_EXEC, TYPE_CANCEL: begin
               if (p >= 19 && p < 23) b = m.shares[8*(22-p) +: 8];
            end
            TYPE_REPLACE: begin
               if (p >= 19 && p < 27) b = m.nref[8*(26-p) +: 8];
               else if (p >= 27 && p < 31) b = m.shares[8*(30-p) +: 8];
               else if (p >= 31 && p < 35) b = m.price[8*(34-p) +: 8];
            end
            default: ;
         endcase
      end
      return b;
   endfunction

   task automatic put_word(input logic k, input logic [7:0] b);
      logic    made;
      rsp_type res;
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= k;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      words_sent++;
      decode_word(k, b, made, res);
      if (made) begin
         cmds_due.push_back(typed_ok ? typed_word : res);
         typed_ok = 1'b0;
      end
   endtask

   task automatic send_msg(input order_msg_type m, input int len_bytes,
                           input logic [15:0] len_field, input int body_sent,
                           input logic eos_after);
      if (len_bytes > 0) put_word(1'b0, len_field[15:8]);
      if (len_bytes > 1) put_word(1'b0, len_field[7:0]);
      for (int p = 0; p < body_sent; p++) put_word(1'b0, msg_byte(m, p));
      if (eos_after) put_word(1'b1, 8'($urandom_range(255)));
   endtask

   task automatic wait_results();
      req_push <= 1'b0;
      do @(posedge clock); while (cmds_due.size() != 0);
   endtask

   task automatic send_random_msg();
      order_msg_type m;
      int       need;
      int       len;
      int       pick;
      m.oref = {$urandom, $urandom};
      m.nref = {$urandom, $urandom};
      m.shares = $urandom;
      m.price = $urandom;
      m.side = ($urandom_range(1) == 0) ? SIDE_BUY : 8'($urandom_range(255));
      case ($urandom_range(5))
         0: begin
            m.mtype = TYPE_ADD;
            need = 36;
         end
         1: begin
            m.mtype = TYPE_ADD_ATTR;
            need = 36;
         end
         2: begin
            m.mtype = TYPE_EXEC;
            need = 31;
         end
         3: begin
            m.mtype = TYPE_CANCEL;
            need = 23;
         end
         4: begin
            m.mtype = TYPE_DELETE;
            need = 19;
         end
         default: begin
            m.mtype = TYPE_REPLACE;
            need = 35;
         end
      endcase
      pick = $urandom_range(99);
      if (pick < 3) begin
         len = $urandom_range(600, 256);
         send_msg(m, 2, 16'(len), len, 1'b0);
      end else if (pick < 68) begin
         len = need + $urandom_range(6);
         send_msg(m, 2, 16'(len), len, 1'b0);
      end else if (pick < 80) begin
         len = $urandom_range(need - 1, 1);
         send_msg(m, 2, 16'(len), len, 1'b0);
      end else if (pick < 88) begin
         do m.mtype = 8'($urandom_range(255));
         while (m.mtype == TYPE_ADD || m.mtype == TYPE_ADD_ATTR || m.mtype == TYPE_EXEC ||
                m.mtype == TYPE_CANCEL || m.mtype == TYPE_DELETE || m.mtype == TYPE_REPLACE);
         len = $urandom_range(40, 1);
         send_msg(m, 2, 16'(len), len, 1'b0);
      end else if (pick < 94) begin
         // partial message dropped by end of stream
         len = need + $urandom_range(6);
         send_msg(m, 2, 16'(len), $urandom_range(len - 1), 1'b1);
      end else if (pick < 97) begin
         send_msg(m, 2, 16'd0, $urandom_range(10), 1'b1);
      end else begin
         send_msg(m, $urandom_range(1), 16'($urandom_range(16'hFFFF)), 0, 1'b1);
      end
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         n_errors++;
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (cmds_due.size() == 0) begin
            n_errors++;
            $error("result word with none expected, cmd %0d", rsp_cmd);
         end else begin
            want = cmds_due.pop_front();
            check_field("cmd", want.cmd, rsp_cmd);
            check_field("order_ref", want.order_ref, rsp_order_ref);
            check_field("new_ref", want.new_ref, rsp_new_ref);
            check_field("side_sell", want.side_sell, rsp_side_sell);
            check_field("share_count", want.share_count, rsp_share_count);
            check_field("limit_price", want.limit_price, rsp_limit_price);
            check_field("processed_count", want.processed_count, rsp_processed_count);
            check_field("malformed_count", want.malformed_count, rsp_malformed_count);
            check_field("skipped_count", want.skipped_count, rsp_skipped_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_end;
      probe_rows = '{
         // end of stream with nothing in flight
         '{'{8'h00, 64'h0, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd0, 16'd0, 16'd0, 1'b1, 1'b0,
           NO_RSP},
         '{'{TYPE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
           2'd2, 16'd36, 16'd36, 1'b0, 1'b1,
           '{CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'd1, 32'd0, 32'd0}},
         '{'{TYPE_ADD_ATTR, 64'h0, 64'h0, 8'h53, 32'h0, 32'h0}, 2'd2, 16'd36, 16'd36, 1'b0, 1'b1,
           '{CMD_ADD, 64'h0, 64'h0, 1'b1, 32'h0, 32'h0, 32'd2, 32'd0, 32'd0}},
         '{'{TYPE_EXEC, 64'h0123_4567_89AB_CDEF, 64'h0, 8'h00, 32'h0000_1000, 32'h0},
           2'd2, 16'd31, 16'd31, 1'b0, 1'b0, NO_RSP},
         '{'{TYPE_CANCEL, 64'hFEDC_BA98_7654_3210, 64'h0, 8'h00, 32'h8000_0001, 32'h0},
           2'd2, 16'd23, 16'd23, 1'b0, 1'b0, NO_RSP},
         '{'{TYPE_DELETE, 64'h8000_0000_0000_0001, 64'h0, 8'h00, 32'h0, 32'h0},
           2'd2, 16'd19, 16'd19, 1'b0, 1'b0, NO_RSP},
         '{'{TYPE_REPLACE, 64'h1111_2222_3333_4444, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
             32'hFFFF_FFFF, 32'h7FFF_FFFF}, 2'd2, 16'd35, 16'd35, 1'b0, 1'b0, NO_RSP},
         // one byte short of each type, and a one-byte body
         '{'{TYPE_ADD, 64'h5, 64'h0, SIDE_BUY, 32'h5, 32'h5}, 2'd2, 16'd35, 16'd35, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd7, 32'd1, 32'd0}},
         '{'{TYPE_EXEC, 64'h5, 64'h0, 8'h00, 32'h5, 32'h0}, 2'd2, 16'd30, 16'd30, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd8, 32'd2, 32'd0}},
         '{'{TYPE_CANCEL, 64'h5, 64'h0, 8'h00, 32'h5, 32'h0}, 2'd2, 16'd22, 16'd22, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd9, 32'd3, 32'd0}},
         '{'{TYPE_DELETE, 64'h5, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd2, 16'd18, 16'd18, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd10, 32'd4, 32'd0}},
         '{'{TYPE_REPLACE, 64'h5, 64'h5, 8'h00, 32'h5, 32'h5}, 2'd2, 16'd34, 16'd34, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd11, 32'd5, 32'd0}},
         '{'{TYPE_ADD_ATTR, 64'h0, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd2, 16'd1, 16'd1, 1'b0, 1'b1,
           '{CMD_MALFORMED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd12, 32'd6, 32'd0}},
         // unknown types
         '{'{8'h00, 64'h0, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd2, 16'd1, 16'd1, 1'b0, 1'b1,
           '{CMD_SKIPPED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd13, 32'd6, 32'd1}},
         '{'{8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd2, 16'd40, 16'd40,
           1'b0, 1'b1, '{CMD_SKIPPED, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 32'd14, 32'd6, 32'd2}},
         // longer body than needed; a body and a length cut short by end of stream
         '{'{TYPE_ADD, 64'hA5A5_5A5A_A5A5_5A5A, 64'h0, 8'hC2, 32'h1234_5678, 32'h9ABC_DEF0},
           2'd2, 16'd60, 16'd60, 1'b0, 1'b0, NO_RSP},
         '{'{TYPE_REPLACE, 64'h1, 64'h2, 8'h00, 32'h3, 32'h4}, 2'd2, 16'd35, 16'd20, 1'b1, 1'b0,
           NO_RSP},
         '{'{TYPE_DELETE, 64'h0F0F_0F0F_F0F0_F0F0, 64'h0, 8'h00, 32'h0, 32'h0},
           2'd2, 16'd19, 16'd19, 1'b0, 1'b0, NO_RSP},
         '{'{8'h00, 64'h0, 64'h0, 8'h00, 32'h0, 32'h0}, 2'd1, 16'hFF00, 16'd0, 1'b1, 1'b0,
           NO_RSP},
         // zero length halts until end of stream
         '{'{TYPE_ADD, 64'h7, 64'h0, SIDE_BUY, 32'h7, 32'h7}, 2'd2, 16'd0, 16'd12, 1'b1, 1'b0,
           NO_RSP},
         '{'{TYPE_CANCEL, 64'h0000_0000_0000_00FF, 64'h0, 8'h00, 32'h0000_FFFF, 32'h0},
           2'd2, 16'd23, 16'd23, 1'b0, 1'b0, NO_RSP},
         '{'{TYPE_DELETE, 64'hDEAD_0000_BEEF_0001, 64'h0, 8'h00, 32'h0, 32'h0},
           2'd2, 16'hFFFF, 16'd40, 1'b1, 1'b0, NO_RSP},
         '{'{TYPE_EXEC, 64'h0, 64'h0, 8'h00, 32'hFFFF_FFFF, 32'h0}, 2'd2, 16'd31, 16'd31,
           1'b0, 1'b0, NO_RSP}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (probe_rows[i]) begin
         typed_ok = probe_rows[i].typed;
         typed_word = probe_rows[i].want;
         send_msg(probe_rows[i].m, probe_rows[i].len_bytes, probe_rows[i].len_field,
                  probe_rows[i].body_sent, probe_rows[i].eos_after);
         wait_results();
      end
      typed_ok = 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = send_pcts[ph];
         pop_stall = stall_pcts[ph];
         // long receiver hold-off so the block backs up into req_full
         if (ph == 0) hold_left = LONG_HOLD;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_random_msg();
         wait_results();
      end
      repeat (10) @(posedge clock);
      if (cmds_due.size() != 0) begin
         n_errors++;
         $error("%0d result words never arrived", cmds_due.size());
      end
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/iomd_pkg.sv
src/iomd_fifo.sv
src/iomd_front.sv
src/iomd_back.sv
src/itch_order_message_decoder_core.sv
tb/tb_itch_order_message_decoder_core.sv
